// ===== rtl/crptp_pkg.sv =====
// Shared types and codes for the credit priority task picker.
package crptp_pkg;

    typedef enum logic [1:0] {
        ACT_TICK,
        ACT_CREATE,
        ACT_DELETE,
        ACT_SET_STATUS
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK_SCAN,
        S_TICK_LAST,
        S_TICK_FIN,
        S_RELOAD,
        S_RELOAD_LAST,
        S_CREATE_SCAN,
        S_CHECK,
        S_SET_WR
    } t_state;

    localparam logic [1:0] ST_READY = 2'd0;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_NO_READY = 2'd1;
    localparam logic [1:0] ERR_NO_FREE  = 2'd2;
    localparam logic [1:0] ERR_UNUSED   = 2'd3;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] prio;
        logic [7:0] credit;
    } t_slot;

endpackage

// ===== rtl/credit_priority_task_picker_core.sv =====
// Credit priority task picker: slot table in a synchronous memory, sequenced access.
//
// A transaction is accepted when start is high and busy is low; each produces exactly
// one result, shown on o_result_id, o_ok and o_error_code for one cycle with o_done
// high. The receiver cannot stall, so the result must be taken in that cycle. The slot
// fields (status, priority, credit) live in one synchronous memory of NUM_TASKS entries
// with one registered read port and one write port; the in-use marks are flip-flops
// cleared by reset, and an unused entry is never consulted, so the memory needs no
// clearing pass. Transactions are sequenced as passes over that memory, one entry per
// cycle: a schedule tick scans every slot and then writes back the winner's decremented
// credit; when that credit reaches zero, a reload pass instead reloads every ready slot.
// Create walks the in-use marks from slot 0 until it finds a free slot; delete, and any
// request on an unused slot, finish in the check step; set status takes a check, then a
// read-modify-write of the entry.
module credit_priority_task_picker_core #(
    parameter int NUM_TASKS      = 16,
    parameter int INITIAL_CREDIT = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_action,
    input  logic [3:0] i_task_id,
    input  logic [7:0] i_priority_req,
    input  logic [1:0] i_new_status,
    output logic       o_done,
    output logic [3:0] o_result_id,
    output logic       o_ok,
    output logic [1:0] o_error_code
);
    import crptp_pkg::*;

    localparam int               IDX_W = $clog2(NUM_TASKS);
    localparam logic [IDX_W-1:0] LAST  = IDX_W'(NUM_TASKS - 1);
    localparam logic [7:0]       INIT_CREDIT = 8'(INITIAL_CREDIT);

    // Slot table memory and its registered read port
    t_slot r_mem [NUM_TASKS];
    t_slot r_rd_data;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    t_slot            mem_wdata;
    logic [IDX_W-1:0] mem_raddr;

    // Control and datapath registers
    t_state           r_state, n_state;
    logic [NUM_TASKS-1:0] r_used, n_used;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_pipe_vld;
    logic [IDX_W-1:0] r_pipe_idx;
    t_action          r_op;
    logic [3:0]       r_id;
    logic [7:0]       r_prio;
    logic [1:0]       r_new_status;
    logic             r_best_vld;
    logic [IDX_W-1:0] r_best_idx;
    logic [7:0]       r_best_credit;
    logic [7:0]       r_best_prio;
    logic [31:0]      r_tick_count;

    logic             r_done, n_done;
    logic [3:0]       r_result_id, n_result_id;
    logic             r_ok, n_ok;
    logic [1:0]       r_error_code, n_error_code;

    logic             accept;
    logic [IDX_W+3:0] id_wide;
    logic [IDX_W-1:0] id_idx;
    logic             id_valid;
    logic             pipe_ready;
    logic             better;
    logic             tick_cmp;
    logic [7:0]       new_credit;
    logic [IDX_W+3:0] best_wide;
    logic [IDX_W+3:0] idx_wide;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // Map the 4-bit task id onto the slot index space, whatever IDX_W is
    assign id_wide  = {{IDX_W{1'b0}}, r_id};
    assign id_idx   = id_wide[IDX_W-1:0];
    assign id_valid = (id_wide < (IDX_W + 4)'(NUM_TASKS)) && r_used[id_idx];

    // Result ids carry only the low four bits of a slot index
    assign best_wide = {4'b0, r_best_idx};
    assign idx_wide  = {4'b0, r_idx};

    // Entry arriving from the read port: is it an in-use ready slot?
    assign pipe_ready = r_used[r_pipe_idx] && (r_rd_data.status == ST_READY);

    // Most credit wins; a tie goes to equal-or-higher priority, i.e. the later slot
    assign better = !r_best_vld
                 || (r_rd_data.credit > r_best_credit)
                 || ((r_rd_data.credit == r_best_credit) && (r_rd_data.prio >= r_best_prio));

    assign tick_cmp = r_pipe_vld && pipe_ready && better
                   && ((r_state == S_TICK_SCAN) || (r_state == S_TICK_LAST));

    assign new_credit = (r_best_credit == 8'd0) ? 8'd0 : (r_best_credit - 8'd1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_action'(i_action))
                        ACT_TICK:       n_state = S_TICK_SCAN;
                        ACT_CREATE:     n_state = S_CREATE_SCAN;
                        ACT_DELETE,
                        ACT_SET_STATUS: n_state = S_CHECK;
                        default:        n_state = S_IDLE;
                    endcase
                end
            end
            S_TICK_SCAN:   if (r_idx == LAST) n_state = S_TICK_LAST;
            S_TICK_LAST:   n_state = S_TICK_FIN;
            S_TICK_FIN: begin
                if (r_best_vld && (new_credit == 8'd0)) n_state = S_RELOAD;
                else                                    n_state = S_IDLE;
            end
            S_RELOAD:      if (r_idx == LAST) n_state = S_RELOAD_LAST;
            S_RELOAD_LAST: n_state = S_IDLE;
            S_CREATE_SCAN: if (!r_used[r_idx] || (r_idx == LAST)) n_state = S_IDLE;
            S_CHECK: begin
                if (id_valid && (r_op == ACT_SET_STATUS)) n_state = S_SET_WR;
                else                                      n_state = S_IDLE;
            end
            S_SET_WR:      n_state = S_IDLE;
            default:       n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: memory access, in-use marks, scan index, result
    always_comb begin
        mem_we       = 1'b0;
        mem_waddr    = r_idx;
        mem_wdata    = '0;
        mem_raddr    = r_idx;
        n_used       = r_used;
        n_idx        = r_idx;
        n_done       = 1'b0;
        n_result_id  = r_result_id;
        n_ok         = r_ok;
        n_error_code = r_error_code;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
            end
            S_TICK_SCAN: begin
                n_idx = r_idx + IDX_W'(1);
            end
            S_TICK_LAST: begin
                n_idx = '0;
            end
            S_TICK_FIN: begin
                n_idx = '0;
                if (!r_best_vld) begin
                    n_done       = 1'b1;
                    n_result_id  = 4'd0;
                    n_ok         = 1'b0;
                    n_error_code = ERR_NO_READY;
                end else if (new_credit != 8'd0) begin
                    // Decrement only; a credit that hits zero is rewritten by the reload
                    mem_we       = 1'b1;
                    mem_waddr    = r_best_idx;
                    mem_wdata    = '{status: ST_READY, prio: r_best_prio, credit: new_credit};
                    n_done       = 1'b1;
                    n_result_id  = best_wide[3:0];
                    n_ok         = 1'b1;
                    n_error_code = ERR_NONE;
                end
            end
            S_RELOAD, S_RELOAD_LAST: begin
                if (r_state == S_RELOAD) begin
                    n_idx = r_idx + IDX_W'(1);
                end
                // Write back one entry behind the read, so the two never touch the same slot
                if (r_pipe_vld && pipe_ready) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pipe_idx;
                    mem_wdata = '{status: r_rd_data.status, prio: r_rd_data.prio,
                                  credit: r_rd_data.prio};
                end
                if (r_state == S_RELOAD_LAST) begin
                    n_done       = 1'b1;
                    n_result_id  = best_wide[3:0];
                    n_ok         = 1'b1;
                    n_error_code = ERR_NONE;
                end
            end
            S_CREATE_SCAN: begin
                if (!r_used[r_idx]) begin
                    mem_we         = 1'b1;
                    mem_waddr      = r_idx;
                    mem_wdata      = '{status: ST_READY, prio: r_prio, credit: INIT_CREDIT};
                    n_used[r_idx]  = 1'b1;
                    n_done         = 1'b1;
                    n_result_id    = idx_wide[3:0];
                    n_ok           = 1'b1;
                    n_error_code   = ERR_NONE;
                end else if (r_idx == LAST) begin
                    n_done       = 1'b1;
                    n_result_id  = 4'd0;
                    n_ok         = 1'b0;
                    n_error_code = ERR_NO_FREE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_CHECK: begin
                mem_raddr = id_idx;
                if (!id_valid) begin
                    n_done       = 1'b1;
                    n_result_id  = r_id;
                    n_ok         = 1'b0;
                    n_error_code = ERR_UNUSED;
                end else if (r_op == ACT_DELETE) begin
                    mem_we         = 1'b1;
                    mem_waddr      = id_idx;
                    mem_wdata      = '0;
                    n_used[id_idx] = 1'b0;
                    n_done         = 1'b1;
                    n_result_id    = r_id;
                    n_ok           = 1'b1;
                    n_error_code   = ERR_NONE;
                end
            end
            S_SET_WR: begin
                mem_we       = 1'b1;
                mem_waddr    = id_idx;
                mem_wdata    = '{status: r_new_status, prio: r_rd_data.prio,
                                 credit: r_rd_data.credit};
                n_done       = 1'b1;
                n_result_id  = r_id;
                n_ok         = 1'b1;
                n_error_code = ERR_NONE;
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    // Slot table memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used       <= '0;
            r_pipe_vld   <= 1'b0;
            r_best_vld   <= 1'b0;
            r_done       <= 1'b0;
            r_tick_count <= '0;
        end else begin
            r_state    <= n_state;
            r_used     <= n_used;
            r_pipe_vld <= (r_state == S_TICK_SCAN) || (r_state == S_RELOAD);
            r_done     <= n_done;
            if (accept && (t_action'(i_action) == ACT_TICK)) begin
                r_tick_count <= r_tick_count + 32'd1;
            end
            // Drop the previous winner at the start of each transaction
            if (accept) begin
                r_best_vld <= 1'b0;
            end else if (tick_cmp) begin
                r_best_vld <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_pipe_idx   <= r_idx;
        r_result_id  <= n_result_id;
        r_ok         <= n_ok;
        r_error_code <= n_error_code;
        if (accept) begin
            r_op         <= t_action'(i_action);
            r_id         <= i_task_id;
            r_prio       <= i_priority_req;
            r_new_status <= i_new_status;
        end
        if (tick_cmp) begin
            r_best_idx    <= r_pipe_idx;
            r_best_credit <= r_rd_data.credit;
            r_best_prio   <= r_rd_data.prio;
        end
    end

    assign o_done       = r_done;
    assign o_result_id  = r_result_id;
    assign o_ok         = r_ok;
    assign o_error_code = r_error_code;

`ifndef SYNTHESIS
    a_done_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while a transaction is still in progress");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not start the sequencer");

    a_ok_matches_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_ok == (o_error_code == ERR_NONE)))
        else $error("ok flag disagrees with error code");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("slot table written while idle");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the credit priority task picker core.
module testbench;
    import crptp_pkg::*;

    localparam int SLOTS      = 16;
    localparam int START_CRED = 10;
    localparam int CYCLE_CAP  = 500000;
    localparam int TAIL_WAIT  = 40;

    typedef struct {
        t_action    act;
        logic [3:0] id;
        logic [7:0] prio;
        logic [1:0] st;
        bit         drain;   // hold this transaction until every result is back
        bit         idle_ok; // allow random gaps in front of this transaction
    } t_cmd;

    typedef struct {
        logic [3:0] id;
        logic       ok;
        logic [1:0] err;
    } t_outcome;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [1:0] i_action;
    logic [3:0] i_task_id;
    logic [7:0] i_priority_req;
    logic [1:0] i_new_status;
    logic       o_done;
    logic [3:0] o_result_id;
    logic       o_ok;
    logic [1:0] o_error_code;

    t_cmd     cmd_q[$];
    t_outcome outcome_q[$];
    int       err_count = 0;
    int       cycle_cnt = 0;
    bit       took_cmd  = 1'b0;

    // Shadow copy of the slot table, advanced once per accepted transaction.
    logic       sh_used[SLOTS]   = '{default: 1'b0};
    logic [1:0] sh_status[SLOTS] = '{default: ST_READY};
    logic [7:0] sh_prio[SLOTS]   = '{default: 8'd0};
    logic [7:0] sh_credit[SLOTS] = '{default: 8'd0};
    logic [31:0] sh_ticks = 32'd0;

    credit_priority_task_picker_core #(
        .NUM_TASKS     (SLOTS),
        .INITIAL_CREDIT(START_CRED)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_task_id     (i_task_id),
        .i_priority_req(i_priority_req),
        .i_new_status  (i_new_status),
        .o_done        (o_done),
        .o_result_id   (o_result_id),
        .o_ok          (o_ok),
        .o_error_code  (o_error_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit slot_ready(int i);
        return sh_used[i] && sh_status[i] == ST_READY;
    endfunction

    // Advance the shadow table by one transaction and queue the outcome it must produce.
    task automatic predict_slot_action(t_action act, logic [3:0] id, logic [7:0] prio,
                                       logic [1:0] st);
        t_outcome res;
        int       best;
        int       i;
        best = -1;
        res  = '{id: 4'd0, ok: 1'b0, err: ERR_NONE};
        case (act)
            ACT_TICK: begin
                sh_ticks = sh_ticks + 32'd1;
                // Most credit wins; ties go to higher priority, then higher slot.
                for (i = 0; i < SLOTS; i++) begin
                    if (slot_ready(i)) begin
                        if (best < 0)
                            best = i;
                        else if (sh_credit[i] > sh_credit[best] ||
                                 (sh_credit[i] == sh_credit[best] &&
                                  sh_prio[i] >= sh_prio[best]))
                            best = i;
                    end
                end
                if (best < 0) begin
                    res.err = ERR_NO_READY;
                end else begin
                    // Saturate at zero, then reload every ready slot once drained.
                    if (sh_credit[best] != 8'd0)
                        sh_credit[best] = sh_credit[best] - 8'd1;
                    if (sh_credit[best] == 8'd0) begin
                        for (i = 0; i < SLOTS; i++)
                            if (slot_ready(i))
                                sh_credit[i] = sh_prio[i];
                    end
                    res.id = best[3:0];
                    res.ok = 1'b1;
                end
            end
            ACT_CREATE: begin
                for (i = 0; i < SLOTS && best < 0; i++)
                    if (!sh_used[i])
                        best = i;
                if (best < 0) begin
                    res.err = ERR_NO_FREE;
                end else begin
                    sh_used[best]   = 1'b1;
                    sh_status[best] = ST_READY;
                    sh_prio[best]   = prio;
                    sh_credit[best] = START_CRED[7:0];
                    res.id = best[3:0];
                    res.ok = 1'b1;
                end
            end
            default: begin
                // Delete and set status echo the slot id whether or not they succeed.
                res.id = id;
                if (!sh_used[id]) begin
                    res.err = ERR_UNUSED;
                end else begin
                    if (act == ACT_DELETE) begin
                        sh_used[id]   = 1'b0;
                        sh_status[id] = ST_READY;
                        sh_prio[id]   = 8'd0;
                        sh_credit[id] = 8'd0;
                    end else begin
                        sh_status[id] = st;
                    end
                    res.ok = 1'b1;
                end
            end
        endcase
        outcome_q.push_back(res);
    endtask

    task automatic add_cmd(t_action act, int id, int prio, int st, bit drain, bit idle_ok);
        t_cmd c;
        c.act     = act;
        c.id      = id[3:0];
        c.prio    = prio[7:0];
        c.st      = st[1:0];
        c.drain   = drain;
        c.idle_ok = idle_ok;
        cmd_q.push_back(c);
    endtask

    // Driver: change inputs on the falling edge. Start may only move once the
    // current transaction has been taken or while no transaction is offered.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start          <= 1'b0;
            i_action       <= ACT_TICK;
            i_task_id      <= 4'd0;
            i_priority_req <= 8'd0;
            i_new_status   <= ST_READY;
        end else if (!start || took_cmd) begin
            if (cmd_q.size() == 0) begin
                start <= 1'b0;
            end else if (cmd_q[0].drain && outcome_q.size() != 0) begin
                // Hold off until the block has answered everything in flight.
                start <= 1'b0;
            end else if (cmd_q[0].idle_ok && $urandom_range(99) < 25) begin
                start <= 1'b0;
            end else begin
                t_cmd c;
                c = cmd_q.pop_front();
                i_action       <= c.act;
                i_task_id      <= c.id;
                i_priority_req <= c.prio;
                i_new_status   <= c.st;
                start          <= 1'b1;
            end
        end
    end

    // Monitor: sample on the rising edge. Check a returning result against the
    // oldest outcome before predicting a transaction accepted on the same edge.
    always @(posedge i_clk) begin
        t_outcome exp_res;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("DONE: errors detected");
            $finish;
        end
        if (i_rst_n && o_done) begin
            if (outcome_q.size() == 0) begin
                $error("result with no transaction outstanding: id %0d ok %0d err %0d",
                       o_result_id, o_ok, o_error_code);
                err_count++;
            end else begin
                exp_res = outcome_q.pop_front();
                if (o_result_id !== exp_res.id) begin
                    $error("result_id mismatch: expected %0d, got %0d",
                           exp_res.id, o_result_id);
                    err_count++;
                end
                if (o_ok !== exp_res.ok) begin
                    $error("ok mismatch: expected %0d, got %0d", exp_res.ok, o_ok);
                    err_count++;
                end
                if (o_error_code !== exp_res.err) begin
                    $error("error_code mismatch: expected %0d, got %0d",
                           exp_res.err, o_error_code);
                    err_count++;
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            took_cmd <= 1'b1;
            predict_slot_action(t_action'(i_action), i_task_id, i_priority_req,
                                i_new_status);
        end else begin
            took_cmd <= 1'b0;
        end
    end

    initial begin
        int  b;
        int  k;
        int  r;
        bit  wide;
        bit  gaps;
        int  pr;
        int  st;
        t_action act;

        i_rst_n = 1'b0;

        // Directed opening: empty table, unused slots, a full table, odd statuses.
        add_cmd(ACT_TICK, 0, 0, 0, 0, 1);          // nothing ready
        add_cmd(ACT_DELETE, 0, 0, 0, 0, 1);        // slot never used
        add_cmd(ACT_SET_STATUS, 15, 0, 3, 0, 1);   // slot never used
        add_cmd(ACT_CREATE, 0, 255, 0, 0, 1);
        add_cmd(ACT_CREATE, 0, 0, 0, 0, 1);
        add_cmd(ACT_CREATE, 0, 1, 0, 0, 1);
        add_cmd(ACT_CREATE, 0, 2, 0, 0, 1);
        add_cmd(ACT_CREATE, 0, 128, 0, 0, 1);
        add_cmd(ACT_CREATE, 0, 127, 0, 0, 1);
        for (k = 3; k <= 12; k++)
            add_cmd(ACT_CREATE, 15, k, 3, 0, 1);
        add_cmd(ACT_CREATE, 0, 85, 0, 0, 1);       // table full
        add_cmd(ACT_SET_STATUS, 1, 0, 3, 0, 1);    // status three is never ready
        add_cmd(ACT_SET_STATUS, 2, 0, 2, 0, 1);
        add_cmd(ACT_SET_STATUS, 3, 0, 1, 0, 1);
        add_cmd(ACT_TICK, 0, 0, 0, 1, 1);
        add_cmd(ACT_DELETE, 15, 0, 0, 0, 1);
        add_cmd(ACT_TICK, 0, 0, 0, 0, 1);
        add_cmd(ACT_CREATE, 0, 0, 0, 0, 1);        // reuses the freed top slot

        // Random part in blocks; each block picks a priority range and gap policy.
        // Small priorities drain credits fast, so reloads and zero credit show up often.
        for (b = 0; b < 18; b++) begin
            wide = ($urandom_range(3) == 0);
            gaps = !(b >= 6 && b <= 9);
            for (k = 0; k < 100; k++) begin
                r  = $urandom_range(99);
                pr = wide ? $urandom_range(255) : $urandom_range(6);
                st = ($urandom_range(99) < 60) ? 0 : $urandom_range(3, 1);
                if (r < 45)
                    act = ACT_TICK;
                else if (r < 65)
                    act = ACT_CREATE;
                else if (r < 80)
                    act = ACT_DELETE;
                else
                    act = ACT_SET_STATUS;
                add_cmd(act, $urandom_range(15), pr, st, (k == 0 && b % 4 == 3), gaps);
            end
        end

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Wait for the queue to empty and every outstanding result to come back.
        while (cmd_q.size() != 0 || start || outcome_q.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_WAIT) @(negedge i_clk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
